### hw/rtl/ps2mt_pkg.sv
package ps2mt_pkg;

  localparam int unsigned CoordWidthDefault = 12;
  localparam int unsigned BoundW = 13;

  localparam logic [BoundW-1:0] BoundWidthReset  = 13'd640;
  localparam logic [BoundW-1:0] BoundHeightReset = 13'd480;
  localparam int unsigned PosXReset = 320;
  localparam int unsigned PosYReset = 240;

  localparam logic [1:0] FuncByte   = 2'd0;
  localparam logic [1:0] FuncReport = 2'd1;
  localparam logic [1:0] FuncSet    = 2'd2;

  localparam logic CfgBoundWidth  = 1'b0;
  localparam logic CfgBoundHeight = 1'b1;

  localparam logic [7:0] HdrAlwaysOne = 8'h08;
  localparam logic [7:0] HdrBtnMask   = 8'h07;
  localparam logic [7:0] HdrXSign     = 8'h10;
  localparam logic [7:0] HdrYSign     = 8'h20;
  localparam logic [7:0] HdrOvfMask   = 8'hC0;

  localparam logic [1:0] IdxHeader = 2'd0;
  localparam logic [1:0] IdxXMove  = 2'd1;
  localparam logic [1:0] IdxYMove  = 2'd2;

  typedef enum logic [2:0] {
    StStored  = 3'd0,
    StApplied = 3'd1,
    StOvfDrop = 3'd2,
    StResync  = 3'd3,
    StNotAux  = 3'd4,
    StInject  = 3'd5,
    StSet     = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         data_byte;
    logic               from_aux;
    logic [7:0]         inject_buttons;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
  } item_t;

endpackage

### hw/rtl/ps2mt_clamp.sv
module ps2mt_clamp #(
  parameter int unsigned COORD_WIDTH = ps2mt_pkg::CoordWidthDefault,
  localparam int unsigned SumW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2
) (
  input  logic signed [SumW-1:0]            value_i,
  input  logic [ps2mt_pkg::BoundW-1:0]      bound_i,
  output logic [COORD_WIDTH-1:0]            coord_o
);

  localparam int unsigned LimInt = 1 << COORD_WIDTH;
  localparam logic signed [SumW-1:0] Lim = SumW'(LimInt);

  logic signed [SumW-1:0] bound_ext;
  logic signed [SumW-1:0] bound_sat;
  logic signed [SumW-1:0] hi;

  always_comb begin
    bound_ext = SumW'(bound_i);
    if (bound_ext == '0) begin
      bound_sat = SumW'(1);
    end else if (bound_ext > Lim) begin
      bound_sat = Lim;
    end else begin
      bound_sat = bound_ext;
    end
    hi = bound_sat - SumW'(1);
    if (value_i < 0) begin
      coord_o = '0;
    end else if (value_i > hi) begin
      coord_o = hi[COORD_WIDTH-1:0];
    end else begin
      coord_o = value_i[COORD_WIDTH-1:0];
    end
  end

endmodule

### hw/rtl/ps2mt_tracker.sv
module ps2mt_tracker #(
  parameter int unsigned COORD_WIDTH = ps2mt_pkg::CoordWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  ps2mt_pkg::item_t              item_i,
  input  logic [ps2mt_pkg::BoundW-1:0]  bound_w_i,
  input  logic [ps2mt_pkg::BoundW-1:0]  bound_h_i,
  output logic [COORD_WIDTH-1:0]        pos_x_o,
  output logic [COORD_WIDTH-1:0]        pos_y_o,
  output logic [2:0]                    buttons_o,
  output ps2mt_pkg::status_e            status_o
);

  localparam int unsigned SumW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 2;

  logic [1:0]             byte_index_q, byte_index_d;
  logic [7:0]             header_q, header_d;
  logic [7:0]             xmove_q, xmove_d;
  logic [COORD_WIDTH-1:0] pos_x_q, pos_y_q;
  logic [2:0]             buttons_q, buttons_d;
  logic                   upd_pos;

  logic signed [8:0]      dx9, dy9;
  logic signed [SumW-1:0] pos_x_ext, pos_y_ext;
  logic signed [SumW-1:0] val_x, val_y;
  logic [COORD_WIDTH-1:0] clamp_x, clamp_y;

  assign dx9 = $signed({header_q[4], xmove_q});
  assign dy9 = $signed({header_q[5], item_i.data_byte});
  assign pos_x_ext = SumW'($signed({1'b0, pos_x_q}));
  assign pos_y_ext = SumW'($signed({1'b0, pos_y_q}));

  always_comb begin
    byte_index_d = byte_index_q;
    header_d     = header_q;
    xmove_d      = xmove_q;
    buttons_d    = buttons_q;
    upd_pos      = 1'b0;
    val_x        = pos_x_ext;
    val_y        = pos_y_ext;
    status_o     = ps2mt_pkg::StNotAux;
    unique case (item_i.func)
      ps2mt_pkg::FuncByte: begin
        if (item_i.from_aux) begin
          unique case (byte_index_q)
            ps2mt_pkg::IdxHeader: begin
              if ((item_i.data_byte & ps2mt_pkg::HdrAlwaysOne) != '0) begin
                header_d     = item_i.data_byte;
                byte_index_d = ps2mt_pkg::IdxXMove;
                status_o     = ps2mt_pkg::StStored;
              end else begin
                status_o = ps2mt_pkg::StResync;
              end
            end
            ps2mt_pkg::IdxXMove: begin
              xmove_d      = item_i.data_byte;
              byte_index_d = ps2mt_pkg::IdxYMove;
              status_o     = ps2mt_pkg::StStored;
            end
            default: begin
              byte_index_d = ps2mt_pkg::IdxHeader;
              buttons_d    = 3'(header_q & ps2mt_pkg::HdrBtnMask);
              val_x        = pos_x_ext + SumW'(dx9);
              val_y        = pos_y_ext - SumW'(dy9);
              if ((header_q & ps2mt_pkg::HdrOvfMask) != '0) begin
                status_o = ps2mt_pkg::StOvfDrop;
              end else begin
                upd_pos  = 1'b1;
                status_o = ps2mt_pkg::StApplied;
              end
            end
          endcase
        end
      end
      ps2mt_pkg::FuncReport: begin
        buttons_d = item_i.inject_buttons[2:0];
        val_x     = pos_x_ext + SumW'(item_i.delta_x);
        val_y     = pos_y_ext + SumW'(item_i.delta_y);
        upd_pos   = 1'b1;
        status_o  = ps2mt_pkg::StInject;
      end
      ps2mt_pkg::FuncSet: begin
        val_x    = SumW'(item_i.new_x);
        val_y    = SumW'(item_i.new_y);
        upd_pos  = 1'b1;
        status_o = ps2mt_pkg::StSet;
      end
      default: begin
        status_o = ps2mt_pkg::StNotAux;
      end
    endcase
  end

  ps2mt_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_x (
    .value_i (val_x),
    .bound_i (bound_w_i),
    .coord_o (clamp_x)
  );

  ps2mt_clamp #(.COORD_WIDTH(COORD_WIDTH)) u_clamp_y (
    .value_i (val_y),
    .bound_i (bound_h_i),
    .coord_o (clamp_y)
  );

  assign pos_x_o   = upd_pos ? clamp_x : pos_x_q;
  assign pos_y_o   = upd_pos ? clamp_y : pos_y_q;
  assign buttons_o = buttons_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= ps2mt_pkg::IdxHeader;
      pos_x_q      <= COORD_WIDTH'(ps2mt_pkg::PosXReset);
      pos_y_q      <= COORD_WIDTH'(ps2mt_pkg::PosYReset);
      buttons_q    <= '0;
    end else if (step_i) begin
      byte_index_q <= byte_index_d;
      pos_x_q      <= pos_x_o;
      pos_y_q      <= pos_y_o;
      buttons_q    <= buttons_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      header_q <= header_d;
      xmove_q  <= xmove_d;
    end
  end

endmodule

### hw/rtl/ps2_mouse_packet_tracker_core.sv
// An accepted input word goes to the input register, its result to the result register.
// Throughput: one word per cycle while the master side is ready; the tracker state
// updates as a word moves from the input register to the result register.
// Reset: asynchronous, active low; position 320/240, buttons zero, packet index zero,
// bounds 640/480, both stages empty.
module ps2_mouse_packet_tracker_core #(
  parameter int unsigned COORD_WIDTH = ps2mt_pkg::CoordWidthDefault,
  localparam int unsigned OutDataW = ((2 * COORD_WIDTH + 3 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ps2mt_pkg::BoundW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // data_byte, from_aux, inject_buttons, delta_x, delta_y, new_x, new_y, zero pad
  input  logic [87:0]                   s_axis_tdata_i,
  // func
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // pos_x_out, pos_y_out, buttons_out, zero pad
  output logic [OutDataW-1:0]           m_axis_tdata_o,
  // status
  output logic [2:0]                    m_axis_tuser_o
);

  localparam int unsigned PadW = OutDataW - (2 * COORD_WIDTH + 3);

  logic [ps2mt_pkg::BoundW-1:0] bound_w_q, bound_h_q;
  logic                         in_valid_q, out_valid_q;
  ps2mt_pkg::item_t             item_q;
  logic                         advance;

  logic [COORD_WIDTH-1:0] pos_x, pos_y;
  logic [2:0]             buttons;
  ps2mt_pkg::status_e     status;

  logic [COORD_WIDTH-1:0] out_x_q, out_y_q;
  logic [2:0]             out_btn_q;
  logic [2:0]             out_st_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_w_q <= ps2mt_pkg::BoundWidthReset;
      bound_h_q <= ps2mt_pkg::BoundHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ps2mt_pkg::CfgBoundWidth:  bound_w_q <= cfg_data_i;
        ps2mt_pkg::CfgBoundHeight: bound_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q.func           <= s_axis_tuser_i;
      item_q.data_byte      <= s_axis_tdata_i[7:0];
      item_q.from_aux       <= s_axis_tdata_i[8];
      item_q.inject_buttons <= s_axis_tdata_i[16:9];
      item_q.delta_x        <= s_axis_tdata_i[32:17];
      item_q.delta_y        <= s_axis_tdata_i[48:33];
      item_q.new_x          <= s_axis_tdata_i[64:49];
      item_q.new_y          <= s_axis_tdata_i[80:65];
    end
    if (advance) begin
      out_x_q   <= pos_x;
      out_y_q   <= pos_y;
      out_btn_q <= buttons;
      out_st_q  <= status;
    end
  end

  ps2mt_tracker #(.COORD_WIDTH(COORD_WIDTH)) u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (item_q),
    .bound_w_i (bound_w_q),
    .bound_h_i (bound_h_q),
    .pos_x_o   (pos_x),
    .pos_y_o   (pos_y),
    .buttons_o (buttons),
    .status_o  (status)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_btn_q, out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_st_q;

endmodule
